// ===== hw/rtl/spindle_speed_to_pwm_defines.svh =====
// Assertion macros shared by the spindle speed to PWM checker.
`ifndef SPINDLE_SPEED_TO_PWM_DEFINES_SVH
`define SPINDLE_SPEED_TO_PWM_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SSPWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spindle_speed_to_pwm: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SSPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spindle_speed_to_pwm: next-cycle check failed");

`endif

// ===== hw/rtl/sspwm_pkg.sv =====
// Types and constants shared by the spindle speed to PWM modules.
package sspwm_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SPEED_MIN   = 3'd0,
    CFG_SPEED_MAX   = 3'd1,
    CFG_DUTY_OFF    = 3'd2,
    CFG_DUTY_MIN    = 3'd3,
    CFG_DUTY_MAX    = 3'd4,
    CFG_DUTY_SLOPE  = 3'd5,
    CFG_OFF_AT_ZERO = 3'd6
  } cfg_idx_e;

  // Spindle enable pin requests.
  typedef enum logic [1:0] {
    PIN_NONE = 2'd0,
    PIN_ON   = 2'd1,
    PIN_OFF  = 2'd2
  } pin_req_e;

  // Reset values of the configuration registers.
  localparam logic [15:0] SPEED_MIN_RST = 16'd0;
  localparam logic [15:0] SPEED_MAX_RST = 16'd1000;
  localparam logic [15:0] DUTY_OFF_RST  = 16'd0;
  localparam logic [15:0] DUTY_MIN_RST  = 16'd0;
  localparam logic [15:0] DUTY_MAX_RST  = 16'd65535;
  localparam logic [31:0] DUTY_SLOPE_RST = 32'd0;

  // Hundredths per rpm, and ceil(2^31 / 100) for exact division by 100 of
  // values below 2^24.
  localparam logic [31:0] SPEED_SCALE = 32'd100;
  localparam logic [31:0] RECIP_100   = 32'd21474837;

  // Operands of the shared multiplier.
  typedef struct packed {
    logic [23:0] a;
    logic [31:0] b;
  } mul_req_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] speed_min;
    logic [15:0] speed_max;
    logic [15:0] duty_off;
    logic [15:0] duty_min;
    logic [15:0] duty_max;
    logic [31:0] duty_slope;
    logic        off_at_zero;
  } cfg_t;

endpackage

// ===== hw/rtl/spindle_speed_to_pwm.sv =====
// Top level of the spindle speed to PWM duty mapper.
// Each accepted transaction (speed in rpm and override in percent) yields one
// result: the PWM compare value, the commanded speed, the PWM enable and a
// spindle enable pin request. The result is registered in the last step of
// the sequencer, and a new input is taken in the cycle after the result is
// loaded, so the block works on one item at a time. The sequencer makes six
// passes through the single shared multiplier: the scaled speed, the lower and
// upper speed bounds in hundredths of rpm, the commanded speed by reciprocal
// division, the slope product and its division by 100. A result that is not
// taken holds the sequencer in its last step. Configuration writes are
// accepted in every cycle and must only be made while the block is idle.
module spindle_speed_to_pwm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] speed_request_i,
  input  logic [7:0]  override_pct_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] duty_value_o,
  output logic [15:0] applied_speed_o,
  output logic        pwm_active_o,
  output logic [1:0]  pin_request_o
);
  import sspwm_pkg::*;

  cfg_t        cfg;
  mul_req_t    mul_req;
  logic [55:0] mul_prod;

  // Configuration registers.
  sspwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Shared multiplier.
  sspwm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  // Sequencer and result logic.
  sspwm_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .speed_request_i (speed_request_i),
    .override_pct_i  (override_pct_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .duty_value_o    (duty_value_o),
    .applied_speed_o (applied_speed_o),
    .pwm_active_o    (pwm_active_o),
    .pin_request_o   (pin_request_o),
    .mul_req_o       (mul_req),
    .mul_prod_i      (mul_prod)
  );

endmodule

// ===== hw/rtl/sspwm_cfg.sv =====
// Configuration register file of the spindle speed to PWM block.
module sspwm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output sspwm_pkg::cfg_t   cfg_o
);
  import sspwm_pkg::*;

  cfg_t regs_q;

  // Writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = regs_q;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.speed_min   <= SPEED_MIN_RST;
      regs_q.speed_max   <= SPEED_MAX_RST;
      regs_q.duty_off    <= DUTY_OFF_RST;
      regs_q.duty_min    <= DUTY_MIN_RST;
      regs_q.duty_max    <= DUTY_MAX_RST;
      regs_q.duty_slope  <= DUTY_SLOPE_RST;
      regs_q.off_at_zero <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPEED_MIN:   regs_q.speed_min   <= cfg_data_i[15:0];
        CFG_SPEED_MAX:   regs_q.speed_max   <= cfg_data_i[15:0];
        CFG_DUTY_OFF:    regs_q.duty_off    <= cfg_data_i[15:0];
        CFG_DUTY_MIN:    regs_q.duty_min    <= cfg_data_i[15:0];
        CFG_DUTY_MAX:    regs_q.duty_max    <= cfg_data_i[15:0];
        CFG_DUTY_SLOPE:  regs_q.duty_slope  <= cfg_data_i;
        CFG_OFF_AT_ZERO: regs_q.off_at_zero <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sspwm_mul.sv =====
// Shared registered 24 by 32 bit multiplier.
module sspwm_mul (
  input  logic                clk_i,
  input  sspwm_pkg::mul_req_t req_i,
  output logic [55:0]         prod_o
);
  import sspwm_pkg::*;

  logic [55:0] prod_q;

  // One product per cycle, available in the next cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, req_i.a} * {24'd0, req_i.b};
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/sspwm_core.sv =====
// Sequencer and datapath that map one speed request onto a PWM duty value.
module sspwm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sspwm_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         speed_request_i,
  input  logic [7:0]          override_pct_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         duty_value_o,
  output logic [15:0]         applied_speed_o,
  output logic                pwm_active_o,
  output logic [1:0]          pin_request_o,
  output sspwm_pkg::mul_req_t mul_req_o,
  input  logic [55:0]         mul_prod_i
);
  import sspwm_pkg::*;

  // One multiplier pass per working state; each state after ST_SCALE takes the previous product.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LO,
    ST_HI,
    ST_SPEED,
    ST_PROD,
    ST_QUOT,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [15:0] rpm_q;
  logic [7:0]  ovr_q;
  logic [23:0] s_q;
  logic [22:0] lo_q;
  logic [22:0] hi_q;
  logic [15:0] spd_q;
  logic        big_q;
  logic [22:0] scaled_q;
  logic        running_q;
  logic        out_valid_q;
  logic [15:0] duty_q;
  logic [15:0] speed_q;
  logic        active_q;
  pin_req_e    pin_q;

  logic        out_busy;
  logic [16:0] quot;
  logic [17:0] sum;
  logic        is_top;
  logic        is_zero;
  logic        is_below;
  logic        lin_clamp;
  logic [15:0] top_duty;
  logic [15:0] duty_res;
  logic [15:0] speed_res;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign duty_value_o    = duty_q;
  assign applied_speed_o = speed_q;
  assign pwm_active_o    = active_q;
  assign pin_request_o   = pin_q;
  assign out_busy        = out_valid_q && !out_ready_i;

  // Operand selection for the shared multiplier. The last step repeats the
  // division by 100 so its product stays valid while the output is stalled.
  always_comb begin
    mul_req_o = '0;
    unique case (state_q)
      ST_SCALE: mul_req_o = '{a: {8'd0, rpm_q}, b: {24'd0, ovr_q}};
      ST_LO:    mul_req_o = '{a: {8'd0, cfg_i.speed_min}, b: SPEED_SCALE};
      ST_HI:    mul_req_o = '{a: {8'd0, cfg_i.speed_max}, b: SPEED_SCALE};
      ST_SPEED: mul_req_o = '{a: s_q, b: RECIP_100};
      ST_PROD:  mul_req_o = '{a: s_q - {1'b0, lo_q}, b: cfg_i.duty_slope};
      ST_QUOT:  mul_req_o = '{a: {1'b0, mul_prod_i[38:16]}, b: RECIP_100};
      ST_FIN:   mul_req_o = '{a: {1'b0, scaled_q}, b: RECIP_100};
      default:  mul_req_o = '0;
    endcase
  end

  // Regime decision and linear result, from the last product.
  always_comb begin
    quot      = mul_prod_i[47:31];
    sum       = {1'b0, quot} + {2'd0, cfg_i.duty_min};
    is_top    = (cfg_i.speed_min >= cfg_i.speed_max) || (s_q >= {1'b0, hi_q});
    is_zero   = (s_q == 24'd0);
    is_below  = (s_q <= {1'b0, lo_q});
    lin_clamp = big_q || (sum >= {2'd0, cfg_i.duty_max});
    top_duty  = (cfg_i.duty_max == 16'd0) ? 16'd0 : cfg_i.duty_max - 16'd1;
    if (is_top) begin
      duty_res  = top_duty;
      speed_res = cfg_i.speed_max;
    end else if (is_zero) begin
      duty_res  = cfg_i.duty_off;
      speed_res = 16'd0;
    end else if (is_below) begin
      duty_res  = cfg_i.duty_min;
      speed_res = cfg_i.speed_min;
    end else begin
      duty_res  = lin_clamp ? top_duty : sum[15:0];
      speed_res = spd_q;
    end
  end

  // Sequencer, intermediate values, running flag and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rpm_q       <= '0;
      ovr_q       <= '0;
      s_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      spd_q       <= '0;
      big_q       <= 1'b0;
      scaled_q    <= '0;
      duty_q      <= '0;
      speed_q     <= '0;
      active_q    <= 1'b0;
      pin_q       <= PIN_NONE;
    end else begin
      // In the last step the output register is reloaded instead.
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            rpm_q   <= speed_request_i;
            ovr_q   <= override_pct_i;
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: state_q <= ST_LO;
        ST_LO: begin
          s_q     <= mul_prod_i[23:0];
          state_q <= ST_HI;
        end
        ST_HI: begin
          lo_q    <= mul_prod_i[22:0];
          state_q <= ST_SPEED;
        end
        ST_SPEED: begin
          hi_q    <= mul_prod_i[22:0];
          state_q <= ST_PROD;
        end
        ST_PROD: begin
          spd_q   <= mul_prod_i[46:31];
          state_q <= ST_QUOT;
        end
        ST_QUOT: begin
          // A scaled product of 2^23 or more always lands above the limit.
          big_q    <= |mul_prod_i[55:39];
          scaled_q <= mul_prod_i[38:16];
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_busy) begin
            duty_q      <= duty_res;
            speed_q     <= speed_res;
            out_valid_q <= 1'b1;
            if (duty_res == cfg_i.duty_off) begin
              running_q <= 1'b0;
              active_q  <= 1'b0;
              pin_q     <= cfg_i.off_at_zero ? PIN_OFF : PIN_NONE;
            end else begin
              running_q <= 1'b1;
              active_q  <= 1'b1;
              pin_q     <= running_q ? PIN_NONE : PIN_ON;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sspwm_chk.sv =====
// Port-level checker for the spindle speed to PWM block, bound to the top.
`include "spindle_speed_to_pwm_defines.svh"

module sspwm_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [15:0] speed_request_i,
  input  logic [7:0]  override_pct_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [15:0] duty_value_o,
  input  logic [15:0] applied_speed_o,
  input  logic        pwm_active_o,
  input  logic [1:0]  pin_request_o
);
  import sspwm_pkg::*;

  // A waiting result stays offered until it is taken.
  `SSPWM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // After a transaction is accepted the block is busy working on it.
  `SSPWM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // An off request comes only with the PWM disabled.
  `SSPWM_ASSERT_IMPL(a_off_inactive, out_valid_o && (pin_request_o == PIN_OFF),
                     !pwm_active_o)

  // An on request comes only with the PWM enabled.
  `SSPWM_ASSERT_IMPL(a_on_active, out_valid_o && (pin_request_o == PIN_ON),
                     pwm_active_o)

endmodule

bind spindle_speed_to_pwm sspwm_chk u_sspwm_chk (.*);
